[hw/rtl/mpta_pkg.sv]
// package: types and constants for the timestamp aligner
`timescale 1ns / 1ps
`default_nettype none
package mpta_pkg;
  localparam int NumPortsDef   = 4;
  localparam int QueueDepthDef = 16;
  localparam int StampW        = 27;
  localparam int PayloadW      = 32;
  localparam int DeltaW        = 28;
  localparam int PortW         = 2;

  localparam logic [1:0] StatusAligned = 2'd0;
  localparam logic [1:0] StatusOrder   = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;

  typedef struct packed {
    logic                mode;
    logic [PortW-1:0]    port;
    logic [StampW-1:0]   stamp_ms;
    logic [PayloadW-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [PortW-1:0]    out_port;
    logic [PayloadW-1:0] out_payload;
    logic [DeltaW-1:0]   delta_ms;
    logic                last;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StTailRd, StTailChk, StWrite, StBaseRd, StBaseWait, StScan,
    StRd0, StRd0Wait, StChk0, StRd1Wait, StChk1, StEmit, StReject
  } state_e;
endpackage
`default_nettype wire

[hw/rtl/mpta_ram.sv]
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mpta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/multi_port_timestamp_aligner.sv]
// top level: per-port sample queues and nearest-timestamp aligner
// channel | direction | handshake           | payload
// cmd     | in        | start_i, busy_o     | cmd_i (in_item_t)
// result  | out       | res_valid_o strobe  | res_o (out_item_t)
// cfg     | in        | cfg_valid_i/ready_o | cfg_data_i (base port)
// a push reads and checks the queue tail (not into an empty queue), writes the sample,
// fetches the base port head, scans the base port, reads and checks each other port's
// head, with one more read and check per entry dropped there, all on the single sample
// ram port; an aligned run adds a scan step and one beat per port. reset empties all
// queues; no ram clearing needed. results are strobed one per cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module multi_port_timestamp_aligner
  import mpta_pkg::*;
#(
  parameter int NUM_PORTS   = NumPortsDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire in_item_t   cmd_i,
  output logic            res_valid_o,
  output out_item_t       res_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_data_i
);
  localparam int PW  = $clog2(NUM_PORTS);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int RW  = $clog2(NUM_PORTS + 1);
  localparam int AW  = PW + QW;
  localparam int EW  = StampW + PayloadW;

  state_e state_q, state_d;
  logic [1:0] base_cfg_q;
  logic [QW-1:0] head_q [NUM_PORTS];
  logic [CW-1:0] cnt_q  [NUM_PORTS];
  logic [RW-1:0] resume_q, resume_d;
  logic [PayloadW-1:0] ch_pay_q [NUM_PORTS];
  logic [DeltaW-1:0]   ch_dl_q  [NUM_PORTS];
  in_item_t item_q;
  logic [PW-1:0] base_q, cur_q, ep_q;
  logic [StampW-1:0] bt_q;
  logic [EW-1:0] e0_q;
  logic [1:0] status_q;
  logic [PayloadW-1:0] rd_pay_base_q;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_rd;
  logic [StampW-1:0] rd_stamp;
  logic [PayloadW-1:0] rd_pay;
  logic signed [DeltaW-1:0] d0, d1;

  mpta_ram #(.Width(EW), .Depth(2 ** AW)) u_store (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i({item_q.stamp_ms, item_q.payload}), .rdata_o(ram_rd)
  );

  assign rd_stamp = ram_rd[EW-1:PayloadW];
  assign rd_pay   = ram_rd[PayloadW-1:0];
  assign d0 = DeltaW'(signed'({1'b0, e0_q[EW-1:PayloadW]})) - DeltaW'(signed'({1'b0, bt_q}));
  assign d1 = DeltaW'(signed'({1'b0, rd_stamp})) - DeltaW'(signed'({1'b0, bt_q}));

  logic [PW-1:0] ip, cp;
  logic [PW-1:0] base_sel;
  assign ip = item_q.port[PW-1:0];
  assign cp = cur_q;
  assign base_sel = (32'(base_cfg_q) < NUM_PORTS) ? PW'(base_cfg_q) : '0;

  function automatic logic [AW-1:0] slot(logic [PW-1:0] p, logic [QW-1:0] h,
                                         logic [CW-1:0] k);
    logic [CW:0] s;
    logic [QW-1:0] o;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (32'(s) >= QUEUE_DEPTH) s = s - (CW+1)'(QUEUE_DEPTH);
    o = QW'(s);
    return AW'(p) * AW'(QUEUE_DEPTH) + AW'(o);
  endfunction

  function automatic logic [QW-1:0] next_head(logic [QW-1:0] h);
    return (32'(h) == QUEUE_DEPTH - 1) ? '0 : h + QW'(1);
  endfunction

  logic port_ok;
  assign port_ok = 32'(item_q.port) < NUM_PORTS;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start_i) state_d = StTailRd;
      StTailRd: begin
        if (item_q.mode) state_d = StIdle;
        else if (!port_ok) state_d = StIdle;
        else if (cnt_q[ip] == '0) state_d = StWrite;
        else state_d = StTailChk;
      end
      StTailChk: begin
        if (rd_stamp > item_q.stamp_ms || 32'(cnt_q[ip]) >= QUEUE_DEPTH) state_d = StReject;
        else state_d = StWrite;
      end
      StWrite: state_d = StBaseRd;
      StBaseRd: state_d = (cnt_q[base_sel] == '0) ? StIdle : StBaseWait;
      StBaseWait: state_d = StScan;
      StScan: begin
        if (32'(resume_q) >= NUM_PORTS) state_d = StEmit;
        else if (cp == base_q) state_d = StScan;
        else if (cnt_q[cp] == '0) state_d = StIdle;
        else state_d = StRd0;
      end
      StRd0: state_d = StRd0Wait;
      StRd0Wait: state_d = StChk0;
      StChk0: begin
        if (d0 >= 0) state_d = StScan;
        else if (cnt_q[cp] > CW'(1)) state_d = StRd1Wait;
        else state_d = StIdle;
      end
      StRd1Wait: state_d = StChk1;
      StChk1: state_d = (d1 < 0 || d1 < -d0) ? StRd0 : StScan;
      StEmit: if (32'(ep_q) == NUM_PORTS - 1) state_d = StIdle;
      StReject: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = slot(ip, head_q[ip], cnt_q[ip] - CW'(1));
    unique case (state_q)
      StWrite:  begin ram_we = 1'b1; ram_addr = slot(ip, head_q[ip], cnt_q[ip]); end
      StBaseRd: ram_addr = slot(base_sel, head_q[base_sel], '0);
      StRd0, StRd0Wait: ram_addr = slot(cp, head_q[cp], '0);
      StChk0, StRd1Wait: ram_addr = slot(cp, head_q[cp], CW'(1));
      default: ;
    endcase
    busy_o      = state_q != StIdle;
    cfg_ready_o = state_q == StIdle;
    res_valid_o = state_q == StEmit || state_q == StReject;
    res_o.status      = (state_q == StReject) ? status_q : StatusAligned;
    res_o.out_port    = (state_q == StReject) ? item_q.port : 2'(ep_q);
    res_o.out_payload = (state_q == StReject) ? item_q.payload : ch_pay_q[ep_q];
    res_o.delta_ms    = (state_q == StReject) ? '0 : ch_dl_q[ep_q];
    res_o.last        = (state_q == StReject) || 32'(ep_q) == NUM_PORTS - 1;
  end

  always_comb begin
    resume_d = resume_q;
    if (state_q == StScan && cp == base_q && 32'(resume_q) < NUM_PORTS)
      resume_d = resume_q + RW'(1);
    if (state_q == StChk0 && d0 >= 0) resume_d = resume_q + RW'(1);
    if (state_q == StChk1 && !(d1 < 0 || d1 < -d0)) resume_d = resume_q + RW'(1);
    if (state_q == StScan && 32'(resume_q) >= NUM_PORTS) resume_d = '0;
    if (state_q == StTailRd && item_q.mode) resume_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      base_cfg_q <= '0;
      resume_q   <= '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        head_q[p] <= '0;
        cnt_q[p]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      if (cfg_valid_i && cfg_ready_o) base_cfg_q <= cfg_data_i;
      if (state_q == StTailRd && item_q.mode) begin
        for (int p = 0; p < NUM_PORTS; p++) begin
          head_q[p] <= '0;
          cnt_q[p]  <= '0;
        end
      end
      if (state_q == StWrite) cnt_q[ip] <= cnt_q[ip] + CW'(1);
      if (state_q == StChk1 && (d1 < 0 || d1 < -d0)) begin
        head_q[cp] <= next_head(head_q[cp]);
        cnt_q[cp]  <= cnt_q[cp] - CW'(1);
      end
      if (state_q == StScan && 32'(resume_q) >= NUM_PORTS) begin
        head_q[base_q] <= next_head(head_q[base_q]);
        cnt_q[base_q]  <= cnt_q[base_q] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) item_q <= cmd_i;
    if (state_q == StTailChk)
      status_q <= (rd_stamp > item_q.stamp_ms) ? StatusOrder : StatusFull;
    if (state_q == StBaseRd) base_q <= base_sel;
    if (state_q == StBaseWait) begin
      bt_q  <= rd_stamp;
      cur_q <= PW'(resume_q);
    end
    if (state_q == StRd0Wait) e0_q <= ram_rd;
    if (state_q == StScan) begin
      ep_q <= '0;
      if (cp == base_q && 32'(resume_q) < NUM_PORTS) begin
        ch_pay_q[cp] <= rd_pay_base_q;
        ch_dl_q[cp]  <= '0;
        cur_q <= cp + PW'(1);
      end
    end
    if ((state_q == StChk0 && d0 >= 0) ||
        (state_q == StChk1 && !(d1 < 0 || d1 < -d0))) begin
      ch_pay_q[cp] <= e0_q[PayloadW-1:0];
      ch_dl_q[cp]  <= d0;
      cur_q <= cp + PW'(1);
    end
    if (state_q == StEmit) ep_q <= ep_q + PW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StBaseWait) rd_pay_base_q <= rd_pay;
  end
endmodule
`default_nettype wire

[hw/rtl/mpta_checker.sv]
// port-level checker for the timestamp aligner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mpta_checker
  import mpta_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire logic      busy_o,
  input wire logic      res_valid_o,
  input wire out_item_t res_o,
  input wire logic      cfg_ready_o
);
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o) else $error("result beat while idle");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy_o) else $error("cfg ready while busy");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != StatusAligned) |-> res_o.last)
    else $error("reject beat without last");
endmodule
bind multi_port_timestamp_aligner mpta_checker u_mpta_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .res_valid_o, .res_o, .cfg_ready_o
);
`default_nettype wire
